### sv/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared constants for the half/single float conversion unit.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  localparam logic FuncNarrow = 1'b0;
  localparam logic FuncWiden  = 1'b1;

  localparam logic [15:0] HalfExpAll  = 16'h7c00;
  localparam logic [8:0]  Rebias      = 9'd112;
  localparam logic [7:0]  WidenSubExp = 8'd113;

endpackage

### sv/hsfc_core.sv
// ----------------------------------------------------------------------------
// hsfc_core
// Combinational conversion between binary32 and binary16 encodings.
// ----------------------------------------------------------------------------
module hsfc_core (
  input  logic        func_i,
  input  logic [31:0] operand_i,
  output logic [31:0] converted_o
);
  import hsfc_pkg::*;

  logic [15:0] half_res;
  logic [31:0] single_res;

  // Narrowing: binary32 to binary16, rounding half away from zero.
  logic [15:0] n_sign;
  logic [7:0]  n_exp8;
  logic [22:0] n_mant;
  logic signed [9:0] n_exp;
  logic [23:0] n_sub_mant;
  logic [4:0]  n_shift;
  logic [24:0] n_rounded;
  logic [24:0] n_norm_rnd;
  logic [9:0]  n_nan_mant;
  logic signed [9:0] n_exp_inc;

  always_comb begin
    n_sign     = {operand_i[31], 15'd0};
    n_exp8     = operand_i[30:23];
    n_mant     = operand_i[22:0];
    n_exp      = $signed({2'b00, n_exp8}) - $signed({1'b0, Rebias});
    n_shift    = 5'(10'sd1 - n_exp);
    n_sub_mant = {1'b1, n_mant} >> n_shift;
    n_rounded  = {1'b0, n_sub_mant} + (n_sub_mant[12] ? 25'h2000 : 25'd0);
    n_norm_rnd = {2'b00, n_mant} + (n_mant[12] ? 25'h2000 : 25'd0);
    n_exp_inc  = n_exp + (n_norm_rnd[23] ? 10'sd1 : 10'sd0);
    n_nan_mant = n_mant[22:13];
    if (n_exp <= 10'sd0) begin
      if (n_exp < -10'sd10) half_res = n_sign;
      else half_res = n_sign | {4'd0, n_rounded[24:13]};
    end else if (n_exp8 == 8'hff) begin
      half_res = n_sign | HalfExpAll | {6'd0, n_nan_mant}
               | {15'd0, (n_mant != 23'd0) && (n_nan_mant == 10'd0)};
    end else if (n_exp_inc > 10'sd30) begin
      half_res = n_sign | HalfExpAll;
    end else begin
      half_res = n_sign | {1'b0, n_exp_inc[4:0],
                           (n_norm_rnd[23] ? 10'd0 : n_norm_rnd[22:13])};
    end
  end

  // Widening: binary16 to binary32, exact; subnormals are normalised.
  logic [4:0] w_exp;
  logic [9:0] w_mant;
  logic [3:0] w_lz;
  logic [9:0] w_norm;

  always_comb begin
    w_exp  = operand_i[14:10];
    w_mant = operand_i[9:0];
    w_lz   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (w_mant[i]) w_lz = 4'(9 - i);
    end
    w_norm = 10'(w_mant << (w_lz + 4'd1));
    if (w_exp == 5'h1f) begin
      single_res = {operand_i[15], 8'hff, w_mant, 13'd0};
    end else if (w_exp == 5'd0) begin
      if (w_mant == 10'd0) single_res = {operand_i[15], 31'd0};
      else single_res = {operand_i[15], WidenSubExp - 8'(w_lz) - 8'd1, w_norm, 13'd0};
    end else begin
      single_res = {operand_i[15], 8'({3'd0, w_exp} + Rebias[7:0]), w_mant, 13'd0};
    end
  end

  assign converted_o = (func_i == FuncWiden) ? single_res : {16'd0, half_res};

endmodule

### sv/half_single_float_convert_unit.sv
// ----------------------------------------------------------------------------
// half_single_float_convert_unit
// Converts one IEEE value per item between binary32 and binary16.
// ----------------------------------------------------------------------------
//  Channel | Direction | Signals
//  input   | in        | in_valid_i, in_stall_o, func_i, operand_i
//  output  | out       | out_valid_o, out_stall_i, converted_o
//
// Each item passes through an input register, the conversion logic and a
// result register; one item may enter per cycle unless the output stalls.
// The reset clears only the valid flags; payload registers are not reset.
// A stall on the output backs up through both stages; an item is taken
// whenever the input stage is empty or moving forward.
module half_single_float_convert_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] converted_o
);
  import hsfc_pkg::*;

  logic        s1_valid_q, s2_valid_q;
  logic        func_q;
  logic [31:0] operand_q, converted_q, conv_d;
  logic        s2_move, s1_move;

  // Result stage advances when empty or taken; input stage follows.
  assign s2_move    = !s2_valid_q || !out_stall_i;
  assign s1_move    = !s1_valid_q || s2_move;
  assign in_stall_o = !s1_move;

  hsfc_core u_core (
    .func_i     (func_q),
    .operand_i  (operand_q),
    .converted_o(conv_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_move) s1_valid_q <= in_valid_i;
      if (s2_move) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && in_valid_i) begin
      func_q    <= func_i;
      operand_q <= operand_i;
    end
    if (s2_move && s1_valid_q) converted_q <= conv_d;
  end

  assign out_valid_o = s2_valid_q;
  assign converted_o = converted_q;

  // A stalled result must keep its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(converted_o))
    else $error("stalled result changed");
  // Input stall only arises with both stages full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && out_stall_i)
    else $error("spurious input stall");
  // A narrowed result leaves the upper half clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && func_q == FuncNarrow |-> conv_d[31:16] == 16'd0)
    else $error("narrow upper bits set");

endmodule

### tb/tb_half_single_float_convert_unit.sv
// ----------------------------------------------------------------------------
// tb_half_single_float_convert_unit
// Self-checking testbench for the half/single float conversion unit. Items
// are sent through the valid/stall input channel, each is converted by a
// predictor kept in step with the stimulus, and every result leaving the
// output channel is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_half_single_float_convert_unit;
  import hsfc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = FuncNarrow;
  logic [31:0] operand_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] converted_o;

  // Idle percentages for the sender and the receiver; changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Predicted conversions still waiting for their result item.
  logic [31:0] pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned narrow_sent = 0;
  int unsigned widen_sent = 0;

  half_single_float_convert_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .operand_i  (operand_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .converted_o(converted_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Narrowing from binary32 to binary16. Rounding adds one unit at the guard
  // bit, so ties go away from zero rather than to even.
  function automatic logic [31:0] narrow_to_half(input logic [31:0] x);
    logic [15:0] sgn;
    int          ex;
    logic [31:0] man;
    sgn = {x[31], 15'd0};
    ex  = int'(x[30:23]) - int'(Rebias);
    man = {9'd0, x[22:0]};
    if (ex <= 0) begin
      // Below the half subnormal range everything flushes to signed zero.
      if (ex < -10) return {16'd0, sgn};
      man = (man | 32'h0080_0000) >> (1 - ex);
      if (man[12]) man = man + 32'h0000_2000;
      return {16'd0, sgn | man[28:13]};
    end
    if (ex == 255 - int'(Rebias)) begin
      // Infinity stays infinity; a NaN keeps its top payload bits and is
      // forced nonzero so that it remains a NaN.
      if (man == 0) return {16'd0, sgn | HalfExpAll};
      man = man >> 13;
      return {16'd0, sgn | HalfExpAll | man[15:0] | {15'd0, man == 0}};
    end
    if (man[12]) begin
      man = man + 32'h0000_2000;
      if (man[23]) begin
        man = 0;
        ex  = ex + 1;
      end
    end
    if (ex > 30) return {16'd0, sgn | HalfExpAll};
    return {16'd0, sgn | 16'(ex << 10) | man[28:13]};
  endfunction

  // Widening from binary16 to binary32 is exact; subnormals are normalised.
  function automatic logic [31:0] widen_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [10:0] man;
    logic [7:0]  e32;
    ex  = h[14:10];
    man = {1'b0, h[9:0]};
    if (ex == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
    if (ex == 0) begin
      if (man == 0) return {h[15], 31'd0};
      e32 = WidenSubExp;
      while (!man[10]) begin
        man = man << 1;
        e32 = e32 - 8'd1;
      end
      return {h[15], e32, man[9:0], 13'd0};
    end
    return {h[15], 8'(ex) + 8'(Rebias), h[9:0], 13'd0};
  endfunction

  // Sends one item: optional random idle cycles, then valid held until the
  // block accepts. The prediction is queued when the handshake completes.
  // Valid is lowered by the next idle cycle or by the drain.
  task automatic send_item(input logic fn, input logic [31:0] op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    operand_i  <= op;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(fn == FuncNarrow ? narrow_to_half(op)
                                               : widen_to_single(op[15:0]));
    items_sent++;
    if (fn == FuncNarrow) narrow_sent++; else widen_sent++;
  endtask

  // Wait until every predicted result has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, and a check of every accepted result item.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (out_valid_o && !out_stall_i && rst_ni) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %08h", converted_o);
      end else begin
        want = pending_results.pop_front();
        if (want !== converted_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: converted expected %08h actual %08h", want, converted_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Directed values covering both directions and every special case.
  task automatic test_directed();
    // Narrowing: zeros, a single subnormal, the edge of the tiny range, a
    // half subnormal whose rounding carries into the smallest normal,
    // overflow, rounding carry into overflow, a tie, infinity and NaNs.
    send_item(FuncNarrow, 32'h0000_0000);
    send_item(FuncNarrow, 32'h8000_0000);
    send_item(FuncNarrow, 32'h0000_0001);
    send_item(FuncNarrow, 32'h3300_0000);
    send_item(FuncNarrow, 32'h3280_0000);
    send_item(FuncNarrow, 32'h387f_f000);
    send_item(FuncNarrow, 32'h3f80_0000);
    send_item(FuncNarrow, 32'h3f80_1000);
    send_item(FuncNarrow, 32'h477f_e000);
    send_item(FuncNarrow, 32'h477f_f000);
    send_item(FuncNarrow, 32'hc780_0000);
    send_item(FuncNarrow, 32'h7f7f_ffff);
    send_item(FuncNarrow, 32'h7f80_0000);
    send_item(FuncNarrow, 32'hff80_0001);
    send_item(FuncNarrow, 32'h7fc0_0000);
    send_item(FuncNarrow, 32'hffff_ffff);
    // Widening: zeros, subnormals, normals, infinity, NaN, and upper bits
    // that must be ignored.
    send_item(FuncWiden, 32'h0000_0000);
    send_item(FuncWiden, 32'hffff_8000);
    send_item(FuncWiden, 32'h0000_0001);
    send_item(FuncWiden, 32'h0000_03ff);
    send_item(FuncWiden, 32'h1234_3c00);
    send_item(FuncWiden, 32'h0000_7bff);
    send_item(FuncWiden, 32'h0000_fc00);
    send_item(FuncWiden, 32'hffff_7fff);
    drain_results();
  endtask

  // Random operands, weighted towards the interesting exponent ranges.
  task automatic test_random(input int unsigned count, input int unsigned s_pct,
                             input int unsigned r_pct);
    logic        fn;
    logic [31:0] op;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (count) begin
      fn = 1'($urandom_range(1));
      op = $urandom;
      if (fn == FuncNarrow) begin
        case ($urandom_range(5))
          0: op[30:23] = 8'(100 + $urandom_range(14));  // tiny and subnormal
          1: op[30:23] = 8'(140 + $urandom_range(4));   // near overflow
          2: op[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
          3: op[12:0]  = 13'h1000;                      // exact ties
          default: ;
        endcase
      end else if ($urandom_range(3) == 0) begin
        op[14:10] = $urandom_range(1) ? 5'h1f : 5'h00;
      end
      send_item(fn, op);
    end
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(330, 0, 0);
    test_random(330, 57, 0);
    test_random(330, 0, 57);
    test_random(330, 22, 22);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d items (%0d narrowing, %0d widening), %0d results checked.",
             items_sent, narrow_sent, widen_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_half_single_float_convert_unit passed");
    end else begin
      $display("tb_half_single_float_convert_unit failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_half_single_float_convert_unit failed");
    $finish;
  end

endmodule

### filelist.f
sv/hsfc_pkg.sv
sv/hsfc_core.sv
sv/half_single_float_convert_unit.sv
tb/tb_half_single_float_convert_unit.sv
